// ===== hw/rtl/qegt_pkg.sv =====
// Shared types, register codes and constants for the queue-end green time block.
// No dependencies; imported by every module of the block.
package qegt_pkg;

   localparam int TIME_W    = 48;
   localparam int CFG_W     = 20;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 2 * TIME_W;
   localparam int RSP_W     = 2 * TIME_W;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_HEADWAY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVAL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILING    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GREEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GREEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_START = 3'd5;

   // reset values
   localparam logic [CFG_W-1:0]  RST_HEADWAY     = 20'd3000;
   localparam logic [CFG_W-1:0]  RST_ARRIVAL     = 20'd2000;
   localparam logic [CFG_W-1:0]  RST_TRAILING    = 20'd2000;
   localparam logic [CFG_W-1:0]  RST_MIN_GREEN   = 20'd50000;
   localparam logic [CFG_W-1:0]  RST_MAX_GREEN   = 20'd120000;
   localparam logic [TIME_W-1:0] RST_GREEN_START = 48'd0;

   localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [9:0]        MS_PER_S = 10'd1000;

   // 2^(12*i) mod 1000, used to fold a 48-bit time into its remainder
   localparam logic [6:0] W_12 = 7'd96;
   localparam logic [7:0] W_24 = 8'd216;
   localparam logic [9:0] W_36 = 10'd736;
   // 2^10 mod 1000
   localparam logic [4:0] W_10 = 5'd24;

   typedef struct packed {
      logic [CFG_W-1:0]  headway_limit;
      logic [CFG_W:0]    margin_sum;    // arrival + trailing margin
      logic [TIME_W-1:0] green_lo;      // green start + minimum, saturated
      logic [TIME_W-1:0] green_hi;      // green start + maximum, saturated
   } cfg_type;

   function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/queue_end_green_time_calc.sv =====
// Queue-end green time calculator, top level. rsp_tvalid rises once a run's last vehicle
// has passed the input register, the queue tracking register and six green-end stages.
// Throughput: one vehicle per cycle unless rsp_tready stalls; every stage is a registered
// slot with its own valid. Reset (synchronous, active high) empties the pipeline, restores
// defaults and starts a new run. Depends on qegt_pkg, qegt_csr, qegt_track and qegt_green.
module queue_end_green_time_calc (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: entry_time [47:0], earliest_entry_time [95:48]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [qegt_pkg::REQ_W-1:0]      req_tdata,
   input  logic                            req_tlast,    // last_in_lane
   // tdata: green_end_time [47:0], queue_end_entry_time [95:48]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [qegt_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qegt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qegt_pkg::TIME_W-1:0]     csr_data
);
   import qegt_pkg::*;

   cfg_type           cfg;
   logic              qend_valid;
   logic              qend_ready;
   logic [TIME_W-1:0] qend_time;

   qegt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qegt_track u_track (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qend_valid (qend_valid),
      .qend_ready (qend_ready),
      .qend_time  (qend_time)
   );

   qegt_green u_green (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .qend_valid (qend_valid),
      .qend_ready (qend_ready),
      .qend_time  (qend_time),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/qegt_csr.sv =====
// Configuration registers and the derived clamp bounds and margin sum.
// Depends on qegt_pkg.
module qegt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qegt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qegt_pkg::TIME_W-1:0]     csr_data,
   output qegt_pkg::cfg_type               cfg
);
   import qegt_pkg::*;

   logic [CFG_W-1:0]  headway_ff;
   logic [CFG_W-1:0]  arrival_ff;
   logic [CFG_W-1:0]  trailing_ff;
   logic [CFG_W-1:0]  min_green_ff;
   logic [CFG_W-1:0]  max_green_ff;
   logic [TIME_W-1:0] green_start_ff;
   cfg_type           cfg_ff;
   cfg_type           cfg_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         headway_ff     <= RST_HEADWAY;
         arrival_ff     <= RST_ARRIVAL;
         trailing_ff    <= RST_TRAILING;
         min_green_ff   <= RST_MIN_GREEN;
         max_green_ff   <= RST_MAX_GREEN;
         green_start_ff <= RST_GREEN_START;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HEADWAY:     headway_ff     <= csr_data[CFG_W-1:0];
            CSR_ARRIVAL:     arrival_ff     <= csr_data[CFG_W-1:0];
            CSR_TRAILING:    trailing_ff    <= csr_data[CFG_W-1:0];
            CSR_MIN_GREEN:   min_green_ff   <= csr_data[CFG_W-1:0];
            CSR_MAX_GREEN:   max_green_ff   <= csr_data[CFG_W-1:0];
            CSR_GREEN_START: green_start_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg_in.headway_limit = headway_ff;
      cfg_in.margin_sum    = {1'b0, arrival_ff} + {1'b0, trailing_ff};
      cfg_in.green_lo      = sat_add48(green_start_ff, {{(TIME_W-CFG_W){1'b0}}, min_green_ff});
      cfg_in.green_hi      = sat_add48(green_start_ff, {{(TIME_W-CFG_W){1'b0}}, max_green_ff});
   end

   // derived values registered; user must write only while idle, not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.headway_limit <= RST_HEADWAY;
         cfg_ff.margin_sum    <= {1'b0, RST_ARRIVAL} + {1'b0, RST_TRAILING};
         cfg_ff.green_lo      <= {{(TIME_W-CFG_W){1'b0}}, RST_MIN_GREEN};
         cfg_ff.green_hi      <= {{(TIME_W-CFG_W){1'b0}}, RST_MAX_GREEN};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/qegt_track.sv =====
// Input register and queue-end tracking over one lane's run of vehicles.
// Depends on qegt_pkg; passes the queue-end entry time of each run downstream.
module qegt_track (
   input  logic                         clock,
   input  logic                         reset,
   input  qegt_pkg::cfg_type            cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [qegt_pkg::REQ_W-1:0]   req_tdata,
   input  logic                         req_tlast,
   output logic                         qend_valid,
   input  logic                         qend_ready,
   output logic [qegt_pkg::TIME_W-1:0]  qend_time
);
   import qegt_pkg::*;

   logic              s1_valid_ff;
   logic [TIME_W-1:0] s1_et_ff;
   logic [TIME_W-1:0] s1_eet_ff;
   logic              s1_last_ff;

   logic [TIME_W-1:0] prev_ff;
   logic              awaiting_ff;
   logic              marked_ff;
   logic [TIME_W-1:0] mark_time_ff;

   logic              out_valid_ff;
   logic [TIME_W-1:0] qend_ff;

   logic              s2_rdy;
   logic              s1_rdy;
   logic              s1_move;
   logic [TIME_W:0]   diff;
   logic              gap_ok;
   logic              mark_hit;
   logic              marked_in;
   logic [TIME_W-1:0] mark_time_in;
   logic [TIME_W-1:0] qend_in;

   assign s2_rdy     = !out_valid_ff || qend_ready;
   assign s1_rdy     = !s1_valid_ff || s2_rdy;
   assign s1_move    = s1_valid_ff && s2_rdy;
   assign req_tready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_tvalid) begin
         s1_et_ff   <= req_tdata[TIME_W-1:0];
         s1_eet_ff  <= req_tdata[REQ_W-1:TIME_W];
         s1_last_ff <= req_tlast;
      end
   end

   // a gap that goes negative counts as zero
   always_comb begin
      diff         = {1'b0, s1_et_ff} - {1'b0, prev_ff};
      gap_ok       = diff[TIME_W] ? (cfg.headway_limit == '0)
                                  : (diff[TIME_W-1:0] >= {{(TIME_W-CFG_W){1'b0}},
                                                          cfg.headway_limit});
      mark_hit     = !awaiting_ff && (s1_et_ff == s1_eet_ff) && gap_ok;
      marked_in    = mark_hit || marked_ff;
      mark_time_in = mark_hit ? prev_ff : mark_time_ff;
      qend_in      = marked_in ? mark_time_in : s1_et_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         awaiting_ff <= 1'b1;
         marked_ff   <= 1'b0;
      end else if (s1_move) begin
         prev_ff <= s1_et_ff;
         if (s1_last_ff) begin
            awaiting_ff <= 1'b1;
            marked_ff   <= 1'b0;
         end else begin
            awaiting_ff <= 1'b0;
            marked_ff   <= marked_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         mark_time_ff <= mark_time_in;
      end
   end

   // only the last vehicle of a run moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_rdy) begin
         out_valid_ff <= s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_last_ff) begin
         qend_ff <= qend_in;
      end
   end

   assign qend_valid = out_valid_ff;
   assign qend_time  = qend_ff;

endmodule

// ===== hw/rtl/qegt_green.sv =====
// Green end pipeline: round the queue end up to a whole second, add margins, clamp.
// Depends on qegt_pkg; the remainder mod 1000 is found by folding 12-bit and 10-bit chunks.
module qegt_green (
   input  logic                         clock,
   input  logic                         reset,
   input  qegt_pkg::cfg_type            cfg,
   input  logic                         qend_valid,
   output logic                         qend_ready,
   input  logic [qegt_pkg::TIME_W-1:0]  qend_time,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [qegt_pkg::RSP_W-1:0]   rsp_tdata
);
   import qegt_pkg::*;

   // partial products stage
   logic              p_valid_ff;
   logic [TIME_W-1:0] p_t_ff;
   logic [11:0]       p0_ff;
   logic [18:0]       p1_ff;
   logic [19:0]       p2_ff;
   logic [21:0]       p3_ff;
   logic [18:0]       p1_in;
   logic [19:0]       p2_in;
   logic [21:0]       p3_in;

   // first fold stage
   logic              f_valid_ff;
   logic [TIME_W-1:0] f_t_ff;
   logic [16:0]       f_res_ff;
   logic [22:0]       f_sum;
   logic [16:0]       f_res_in;

   // remainder stage
   logic              r_valid_ff;
   logic [TIME_W-1:0] r_t_ff;
   logic [9:0]        r_rem_ff;
   logic [11:0]       r_v2;
   logic [10:0]       r_v3;
   logic [9:0]        r_rem_in;

   // rounded stage
   logic              u_valid_ff;
   logic [TIME_W-1:0] u_t_ff;
   logic [TIME_W-1:0] u_round_ff;
   logic [9:0]        u_up;
   logic [TIME_W-1:0] u_round_in;

   // margin stage
   logic              m_valid_ff;
   logic [TIME_W-1:0] m_t_ff;
   logic [TIME_W-1:0] m_g_ff;

   // output register
   logic              o_valid_ff;
   logic [TIME_W-1:0] o_t_ff;
   logic [TIME_W-1:0] o_g_ff;
   logic [TIME_W-1:0] o_lo;
   logic [TIME_W-1:0] o_g_in;

   logic rdy_o, rdy_m, rdy_u, rdy_r, rdy_f, rdy_p;

   assign rdy_o      = !o_valid_ff || rsp_tready;
   assign rdy_m      = !m_valid_ff || rdy_o;
   assign rdy_u      = !u_valid_ff || rdy_m;
   assign rdy_r      = !r_valid_ff || rdy_u;
   assign rdy_f      = !f_valid_ff || rdy_r;
   assign rdy_p      = !p_valid_ff || rdy_f;
   assign qend_ready = rdy_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         u_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (rdy_p) p_valid_ff <= qend_valid;
         if (rdy_f) f_valid_ff <= p_valid_ff;
         if (rdy_r) r_valid_ff <= f_valid_ff;
         if (rdy_u) u_valid_ff <= r_valid_ff;
         if (rdy_m) m_valid_ff <= u_valid_ff;
         if (rdy_o) o_valid_ff <= m_valid_ff;
      end
   end

   // chunk times weight, weight = 2^(12i) mod 1000
   always_comb begin
      p1_in = {7'd0, qend_time[23:12]} * {12'd0, W_12};
      p2_in = {8'd0, qend_time[35:24]} * {12'd0, W_24};
      p3_in = {10'd0, qend_time[47:36]} * {12'd0, W_36};
   end

   always_ff @(posedge clock) begin
      if (rdy_p && qend_valid) begin
         p_t_ff <= qend_time;
         p0_ff  <= qend_time[11:0];
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
      end
   end

   // sum < 2^23; fold bits above 12 with 4096 mod 1000 = 96
   always_comb begin
      f_sum    = {11'd0, p0_ff} + {4'd0, p1_ff} + {3'd0, p2_ff} + {1'b0, p3_ff};
      f_res_in = {5'd0, f_sum[11:0]} + ({6'd0, f_sum[22:12]} * {10'd0, W_12});
   end

   always_ff @(posedge clock) begin
      if (rdy_f && p_valid_ff) begin
         f_t_ff   <= p_t_ff;
         f_res_ff <= f_res_in;
      end
   end

   // two more folds by 1024 mod 1000 = 24 leave a value below 2000
   always_comb begin
      r_v2 = {2'd0, f_res_ff[9:0]} + ({5'd0, f_res_ff[16:10]} * {7'd0, W_10});
      r_v3 = {1'b0, r_v2[9:0]} + ({9'd0, r_v2[11:10]} * {6'd0, W_10});
      if (r_v3 >= {1'b0, MS_PER_S}) begin
         r_rem_in = 10'(r_v3 - {1'b0, MS_PER_S});
      end else begin
         r_rem_in = r_v3[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_r && f_valid_ff) begin
         r_t_ff   <= f_t_ff;
         r_rem_ff <= r_rem_in;
      end
   end

   always_comb begin
      u_up       = (r_rem_ff == 10'd0) ? 10'd0 : MS_PER_S - r_rem_ff;
      u_round_in = sat_add48(r_t_ff, {{(TIME_W-10){1'b0}}, u_up});
   end

   always_ff @(posedge clock) begin
      if (rdy_u && r_valid_ff) begin
         u_t_ff     <= r_t_ff;
         u_round_ff <= u_round_in;
      end
   end

   // one saturating add of both margins equals two saturating adds in turn
   always_ff @(posedge clock) begin
      if (rdy_m && u_valid_ff) begin
         m_t_ff <= u_t_ff;
         m_g_ff <= sat_add48(u_round_ff, {{(TIME_W-CFG_W-1){1'b0}}, cfg.margin_sum});
      end
   end

   // lower clamp first, upper clamp wins
   always_comb begin
      o_lo   = (m_g_ff < cfg.green_lo) ? cfg.green_lo : m_g_ff;
      o_g_in = (o_lo > cfg.green_hi) ? cfg.green_hi : o_lo;
   end

   always_ff @(posedge clock) begin
      if (rdy_o && m_valid_ff) begin
         o_t_ff <= m_t_ff;
         o_g_ff <= o_g_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {o_t_ff, o_g_ff};

endmodule

// ===== test/lane_green_end_check.sv =====
// Watches the vehicle, result and register channels of queue_end_green_time_calc, predicts
// each lane's green end and compares it with what the block returns. Depends on qegt_pkg.
`timescale 1ns / 1ps

module lane_green_end_check
   import qegt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0]     csr_data,
   output int                    error_count,
   output int                    results_owed
);

   typedef struct {
      logic [TIME_W-1:0] exp_green;
      logic [TIME_W-1:0] exp_qend;
   } lane_result_type;

   lane_result_type due_q[$];

   // register copy
   logic [CFG_W-1:0]  headway_ms;
   logic [CFG_W-1:0]  arrival_ms;
   logic [CFG_W-1:0]  trailing_ms;
   logic [CFG_W-1:0]  min_green_ms;
   logic [CFG_W-1:0]  max_green_ms;
   logic [TIME_W-1:0] green_start;

   // queue tracking of the current run
   logic [TIME_W-1:0] prev_entry;
   logic              awaiting_first;
   logic              end_marked;
   logic [TIME_W-1:0] marked_entry;
   int                mismatches = 0;

   function automatic logic [TIME_W-1:0] add_clipped(input logic [TIME_W-1:0] a,
                                                      input logic [TIME_W-1:0] b);
      logic [63:0] s;
      s = {16'd0, a} + {16'd0, b};
      return (s > {16'd0, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] predict_green(input logic [TIME_W-1:0] qend);
      logic [63:0]       ms, up;
      logic [TIME_W-1:0] g, lo, hi;
      ms = {54'd0, MS_PER_S};
      up = (({16'd0, qend} + ms - 64'd1) / ms) * ms;
      g  = (up > {16'd0, TIME_MAX}) ? TIME_MAX : up[TIME_W-1:0];
      g  = add_clipped(g, {28'd0, arrival_ms});
      g  = add_clipped(g, {28'd0, trailing_ms});
      lo = add_clipped(green_start, {28'd0, min_green_ms});
      hi = add_clipped(green_start, {28'd0, max_green_ms});
      if (g < lo) g = lo;
      // upper clamp last: it wins when minimum exceeds maximum
      if (g > hi) g = hi;
      return g;
   endfunction

   always @(posedge clock) begin : watch
      logic [TIME_W-1:0] et, eet, gap, qend, got_green, got_qend;
      lane_result_type   due;
      if (reset) begin
         headway_ms     = RST_HEADWAY;
         arrival_ms     = RST_ARRIVAL;
         trailing_ms    = RST_TRAILING;
         min_green_ms   = RST_MIN_GREEN;
         max_green_ms   = RST_MAX_GREEN;
         green_start    = RST_GREEN_START;
         prev_entry     = '0;
         awaiting_first = 1'b1;
         end_marked     = 1'b0;
         marked_entry   = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEADWAY:     headway_ms   = csr_data[CFG_W-1:0];
               CSR_ARRIVAL:     arrival_ms   = csr_data[CFG_W-1:0];
               CSR_TRAILING:    trailing_ms  = csr_data[CFG_W-1:0];
               CSR_MIN_GREEN:   min_green_ms = csr_data[CFG_W-1:0];
               CSR_MAX_GREEN:   max_green_ms = csr_data[CFG_W-1:0];
               CSR_GREEN_START: green_start  = csr_data;
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            et  = req_tdata[TIME_W-1:0];
            eet = req_tdata[2*TIME_W-1:TIME_W];
            if (!awaiting_first && et == eet) begin
               // a vehicle behind its predecessor counts as zero gap
               gap = (et >= prev_entry) ? et - prev_entry : '0;
               if (gap >= {28'd0, headway_ms}) begin
                  end_marked   = 1'b1;
                  marked_entry = prev_entry;
               end
            end
            prev_entry     = et;
            awaiting_first = 1'b0;
            if (req_tlast) begin
               qend          = end_marked ? marked_entry : et;
               due.exp_green = predict_green(qend);
               due.exp_qend  = qend;
               due_q         = {due_q, due};
               awaiting_first = 1'b1;
               end_marked     = 1'b0;
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got_green = rsp_tdata[TIME_W-1:0];
            got_qend  = rsp_tdata[2*TIME_W-1:TIME_W];
            if (due_q.size() == 0) begin
               $error("result transfer with no lane run pending: green_end_time %0d, %s %0d",
                      got_green, "queue_end_entry_time", got_qend);
               mismatches++;
            end else begin
               due = due_q.pop_front();
               if (got_green !== due.exp_green) begin
                  $error("green_end_time: expected %0d, got %0d", due.exp_green, got_green);
                  mismatches++;
               end
               if (got_qend !== due.exp_qend) begin
                  $error("queue_end_entry_time: expected %0d, got %0d",
                         due.exp_qend, got_qend);
                  mismatches++;
               end
            end
         end
      end
      error_count  <= mismatches;
      results_owed <= due_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Stimulus and verdict for queue_end_green_time_calc: directed lane runs, register extremes,
// a long result stall and random runs under four idle patterns. Depends on qegt_pkg and
// lane_green_end_check.
`timescale 1ns / 1ps

module tb_top;
   import qegt_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 16;    // wait past the last result for the pipeline to empty
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 160;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_HEADWAY;
   logic [TIME_W-1:0]    csr_data   = '0;

   int                   error_count;
   int                   results_owed;
   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   int                   hold_request   = 0;
   int                   hold_served    = 0;
   int                   hold_left      = 0;
   int                   cycle_count    = 0;
   logic [CFG_W-1:0]     cur_headway    = RST_HEADWAY;
   logic [TIME_W-1:0]    lane_time      = '0;

   always #HALF_PERIOD clock = ~clock;

   queue_end_green_time_calc uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lane_green_end_check u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   // result side: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request != hold_served) begin
         hold_served <= hold_request;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] later(input logic [TIME_W-1:0] t,
                                                input logic [31:0] d);
      logic [63:0] s;
      s = {16'd0, t} + {32'd0, d};
      return (s > {16'd0, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] earlier(input logic [TIME_W-1:0] t,
                                                  input logic [31:0] d);
      return (t > {16'd0, d}) ? t - {16'd0, d} : '0;
   endfunction

   function automatic logic [CFG_W-1:0] pick_ms(input int unsigned typical);
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = 32'd0;
         1: v = {12'd0, {CFG_W{1'b1}}};
         default: v = $urandom_range(0, typical);
      endcase
      return v[CFG_W-1:0];
   endfunction

   // all tasks start and end at a falling edge
   task automatic push_vehicle(input logic [TIME_W-1:0] et, input logic [TIME_W-1:0] eet,
                               input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {eet, et};
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [CFG_W-1:0] headway, input logic [CFG_W-1:0] arrival,
                                input logic [CFG_W-1:0] trailing, input logic [CFG_W-1:0] min_g,
                                input logic [CFG_W-1:0] max_g, input logic [TIME_W-1:0] start);
      write_reg(CSR_HEADWAY, {28'd0, headway});
      write_reg(CSR_ARRIVAL, {28'd0, arrival});
      write_reg(CSR_TRAILING, {28'd0, trailing});
      write_reg(CSR_MIN_GREEN, {28'd0, min_g});
      write_reg(CSR_MAX_GREEN, {28'd0, max_g});
      write_reg(CSR_GREEN_START, start);
      csr_valid   <= 1'b0;
      cur_headway  = headway;
   endtask

   // stop offering vehicles until every result is back and the pipeline has emptied
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic random_settings();
      logic [TIME_W-1:0] start;
      case ($urandom_range(0, 3))
         0: lane_time = {16'd0, $urandom_range(0, 100000)};
         1: lane_time = earlier(TIME_MAX, $urandom_range(0, 2000000));
         default: lane_time = rand_time();
      endcase
      case ($urandom_range(0, 5))
         0: start = '0;
         1: start = TIME_MAX;
         default: start = earlier(lane_time, $urandom_range(0, 100000));
      endcase
      load_settings(pick_ms(20000), pick_ms(5000), pick_ms(5000), pick_ms(200000),
                    pick_ms(300000), start);
   endtask

   // one sorted-ish lane run with gaps around the headway limit
   task automatic drive_lane_run(output int count);
      int                len;
      int                k;
      logic [31:0]       hw;
      logic [TIME_W-1:0] et, eet;
      hw  = {12'd0, cur_headway};
      len = ($urandom_range(99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 16);
      lane_time = later(lane_time, $urandom_range(0, 60000));
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 5))
            0: et = later(lane_time, (hw == 0) ? 32'd0 : hw - 1);
            1: et = later(lane_time, hw);
            2: et = later(lane_time, hw + $urandom_range(0, 5000));
            3: et = later(lane_time, $urandom_range(0, 2000));
            4: et = earlier(lane_time, $urandom_range(1, 3000));
            default: et = later(lane_time, $urandom_range(0, 2 * hw + 1));
         endcase
         case ($urandom_range(0, 9))
            6, 7: eet = earlier(et, $urandom_range(1, 5000));
            8: eet = rand_time();
            9: eet = later(et, 1);
            default: eet = et;
         endcase
         push_vehicle(et, eet, k == len - 1);
         lane_time = et;
      end
      count = len;
   endtask

   task automatic random_phase(input int mode);
      int pushed;
      int n;
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
         default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      random_settings();
      pushed = 0;
      while (pushed < PHASE_ITEMS) begin
         if ($urandom_range(99) < 8) begin
            push_vehicle(rand_time(), rand_time(), 1'($urandom_range(0, 1)));
            pushed++;
         end else begin
            drive_lane_run(n);
            pushed += n;
         end
         if ($urandom_range(99) < 2) begin
            // sender pause until the block has returned everything
            req_tvalid <= 1'b0;
            do @(negedge clock); while (results_owed != 0);
         end
      end
      drain();
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: lower clamp, rounding past the top, marks and backward entry
      push_vehicle(48'd0, 48'd0, 1'b1);
      push_vehicle(TIME_MAX, TIME_MAX, 1'b1);
      push_vehicle(48'd1000, 48'd1000, 1'b0);
      push_vehicle(48'd4000, 48'd4000, 1'b0);
      push_vehicle(48'd4500, 48'd0, 1'b1);
      push_vehicle(48'd10000, 48'd10000, 1'b0);
      push_vehicle(48'd5000, 48'd5000, 1'b1);
      push_vehicle(48'd1000, 48'd1000, 1'b0);
      push_vehicle(48'd10000, 48'd10000, 1'b0);
      push_vehicle(48'd20000, 48'd20000, 1'b0);
      push_vehicle(48'd20500, 48'd20500, 1'b1);
      push_vehicle(48'd0, TIME_MAX, 1'b0);
      push_vehicle(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1);
      drain();

      // zero headway, widest margins; writes past the register list are dropped
      write_reg(CSR_UNUSED_LO, TIME_MAX);
      write_reg(CSR_UNUSED_HI, TIME_MAX);
      load_settings('0, '1, '1, '0, '1, '0);
      push_vehicle(48'd10000, 48'd10000, 1'b0);
      push_vehicle(48'd5000, 48'd5000, 1'b1);
      push_vehicle(48'd1234567, 48'd1234567, 1'b1);
      drain();

      // largest headway, minimum above maximum, clamp sums saturate
      load_settings('1, '0, '0, '1, '0, earlier(TIME_MAX, 1000));
      push_vehicle(48'd1001, 48'd1001, 1'b1);
      push_vehicle(48'd0, 48'd0, 1'b0);
      push_vehicle(48'd1048575, 48'd1048575, 1'b1);
      drain();

      // long result stall while single-vehicle runs keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_settings();
      hold_request <= hold_request + 1;
      for (k = 0; k < 60; k++) begin
         lane_time = later(lane_time, $urandom_range(0, 10000));
         push_vehicle(lane_time, lane_time, 1'b1);
      end
      drain();

      for (k = 0; k < 8; k++) random_phase(k % 4);

      if (error_count == 0 && results_owed == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
